@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL. Each macro expands to one labelled
// concurrent assertion, sampled on aclk and switched off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge.
`define WSRQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Whenever ante holds, cons holds at the same edge.
`define WSRQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Whenever ante holds, cons holds at the following edge.
`define WSRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/wsrq_pkg.sv @@
package wsrq_pkg;

    // Ring size and stored task width.
    localparam int RING_DEPTH = 64;
    localparam int TASK_BITS  = 16;

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    // Port field widths.
    localparam int ID_W       = 16;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;
    localparam int ACT_W      = 2;
    localparam int KIND_W     = 2;

    // Input actions.
    localparam logic [ACT_W-1:0] ACT_PUT  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_GET  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_GRAB = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_RUN   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SPILL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_THIEF = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_SEND = 3'b100
    } state_t;

    // Ring index plus an offset of at most one full ring, wrapped once.
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] amt);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(amt);
        if (sum >= SUM_W'(RING_DEPTH)) begin
            sum = sum - SUM_W'(RING_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

@@ rtl/core/wsrq_ram.sv @@
module wsrq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/work_stealing_run_queue_top.sv @@
// Per-worker run queue: a ring of task ids with a priority next slot.
// The slave channel carries one command per transaction: put a task, get a
// task for local running, or grab work for a thief. The master channel
// returns the result transactions of each command; tlast marks the final one.
// A put that fits, and an unknown action, is taken while the block stays idle
// and gives no result, so such commands can follow each other in every cycle.
// A get or grab served from the next slot, or answered with "nothing", gives
// its result in the cycle after acceptance; a get served from the ring first
// passes through the load state, where the ring memory is read.
// Every result read from the ring goes through the load state, where the
// registered read of the ring memory happens, and then the send state, which
// presents it on the master channel. A spill of a full ring returns
// RING_DEPTH / 2 ring entries and then the task that did not fit.
// The slave side is ready only while no command is in progress.
// If the receiver holds m_axis_tready low, the result stays registered and
// the sequencer waits; nothing is lost or repeated.
// After reset the ring and the next slot are empty; ring memory contents are
// not cleared, as only entries that have been written are ever read.
module work_stealing_run_queue_top
    import wsrq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [15:0] task_id, [16] put_as_next, [17] steal_next, [23:18] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] action
    input  logic [ACT_W-1:0]     s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [15:0] task_id_res, [16] inherit, [17] is_empty, [23:18] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // [1:0] kind
    output logic [KIND_W-1:0]    m_axis_tuser,
    output logic                 m_axis_tlast
);

`include "assert_macros.svh"

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       head_reg, head_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [TASK_BITS-1:0]   next_task_reg, next_task_next;
    logic                   next_valid_reg, next_valid_next;

    // Sequencer for runs read out of the ring.
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]       rem_reg, rem_next;
    logic                   spill_pend_reg, spill_pend_next;
    logic [TASK_BITS-1:0]   hold_task_reg, hold_task_next;
    logic [KIND_W-1:0]      run_kind_reg, run_kind_next;
    logic                   empty_reg, empty_next;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    logic [TASK_BITS-1:0]   out_task_reg, out_task_next;
    logic [KIND_W-1:0]      out_kind_reg, out_kind_next;
    logic                   out_inherit_reg, out_inherit_next;
    logic                   out_last_reg, out_last_next;

    // Ring memory port.
    logic                   ram_we, ram_re;
    logic [IDX_W-1:0]       ram_waddr, ram_raddr;
    logic [TASK_BITS-1:0]   ram_wdata, ram_rdata;

    logic                   in_fire, out_fire;
    logic [ACT_W-1:0]       in_action;
    logic [TASK_BITS-1:0]   in_task;
    logic                   in_as_next, in_steal;
    logic [TASK_BITS-1:0]   eff_task;
    logic [CNT_W-1:0]       half_cnt, grab_cnt;
    logic                   push_ring;

    assign in_action  = s_axis_tuser;
    assign in_task    = TASK_BITS'(s_axis_tdata[ID_W-1:0]);
    assign in_as_next = s_axis_tdata[ID_W];
    assign in_steal   = s_axis_tdata[ID_W+1];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = out_valid_reg && m_axis_tready;

    assign half_cnt = count_reg >> 1;
    assign grab_cnt = count_reg - half_cnt;

    wsrq_ram #(
        .WIDTH(TASK_BITS),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_en  (ram_re),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    always_comb begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        next_task_next   = next_task_reg;
        next_valid_next  = next_valid_reg;
        rd_idx_next      = rd_idx_reg;
        rem_next         = rem_reg;
        spill_pend_next  = spill_pend_reg;
        hold_task_next   = hold_task_reg;
        run_kind_next    = run_kind_reg;
        empty_next       = empty_reg;
        out_valid_next   = out_valid_reg;
        out_task_next    = out_task_reg;
        out_kind_next    = out_kind_reg;
        out_inherit_next = out_inherit_reg;
        out_last_next    = out_last_reg;
        ram_we           = 1'b0;
        ram_waddr        = wrap_add(head_reg, count_reg);
        ram_wdata        = in_task;
        ram_re           = 1'b0;
        ram_raddr        = head_reg;
        eff_task         = in_task;
        push_ring        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    case (in_action)
                        ACT_PUT: begin
                            push_ring = 1'b1;
                            if (in_as_next) begin
                                next_task_next  = in_task;
                                next_valid_next = 1'b1;
                                eff_task        = next_task_reg;
                                push_ring       = next_valid_reg;
                            end
                            ram_wdata = eff_task;
                            if (push_ring) begin
                                if (count_reg < CNT_W'(RING_DEPTH)) begin
                                    ram_we     = 1'b1;
                                    count_next = count_reg + CNT_W'(1);
                                end else begin
                                    // Full ring: spill the older half, then the task.
                                    ram_re          = 1'b1;
                                    rd_idx_next     = wrap_add(head_reg, CNT_W'(1));
                                    rem_next        = half_cnt - CNT_W'(1);
                                    spill_pend_next = 1'b1;
                                    hold_task_next  = eff_task;
                                    run_kind_next   = KIND_SPILL;
                                    head_next       = wrap_add(head_reg, half_cnt);
                                    count_next      = count_reg - half_cnt;
                                    empty_next      = 1'b0;
                                    state_next      = ST_LOAD;
                                end
                            end
                        end
                        ACT_GET: begin
                            out_inherit_next = 1'b0;
                            out_last_next    = 1'b1;
                            rem_next         = '0;
                            spill_pend_next  = 1'b0;
                            if (next_valid_reg) begin
                                out_valid_next   = 1'b1;
                                out_task_next    = next_task_reg;
                                out_kind_next    = KIND_RUN;
                                out_inherit_next = 1'b1;
                                next_valid_next  = 1'b0;
                                next_task_next   = '0;
                                empty_next       = (count_reg == '0);
                                state_next       = ST_SEND;
                            end else if (count_reg != '0) begin
                                ram_re        = 1'b1;
                                run_kind_next = KIND_RUN;
                                head_next     = wrap_add(head_reg, CNT_W'(1));
                                count_next    = count_reg - CNT_W'(1);
                                empty_next    = (count_reg == CNT_W'(1));
                                state_next    = ST_LOAD;
                            end else begin
                                out_valid_next = 1'b1;
                                out_task_next  = '0;
                                out_kind_next  = KIND_NONE;
                                empty_next     = 1'b1;
                                state_next     = ST_SEND;
                            end
                        end
                        ACT_GRAB: begin
                            out_inherit_next = 1'b0;
                            out_last_next    = 1'b1;
                            spill_pend_next  = 1'b0;
                            if (grab_cnt == '0) begin
                                rem_next       = '0;
                                out_valid_next = 1'b1;
                                state_next     = ST_SEND;
                                if (in_steal && next_valid_reg) begin
                                    out_task_next   = next_task_reg;
                                    out_kind_next   = KIND_THIEF;
                                    next_valid_next = 1'b0;
                                    next_task_next  = '0;
                                    empty_next      = 1'b1;
                                end else begin
                                    out_task_next = '0;
                                    out_kind_next = KIND_NONE;
                                    empty_next    = !next_valid_reg;
                                end
                            end else begin
                                ram_re        = 1'b1;
                                rd_idx_next   = wrap_add(head_reg, CNT_W'(1));
                                rem_next      = grab_cnt - CNT_W'(1);
                                run_kind_next = KIND_THIEF;
                                head_next     = wrap_add(head_reg, grab_cnt);
                                count_next    = half_cnt;
                                empty_next    = (half_cnt == '0) && !next_valid_reg;
                                state_next    = ST_LOAD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOAD: begin
                out_valid_next   = 1'b1;
                out_task_next    = ram_rdata;
                out_kind_next    = run_kind_reg;
                out_inherit_next = 1'b0;
                out_last_next    = (rem_reg == '0) && !spill_pend_reg;
                state_next       = ST_SEND;
            end
            ST_SEND: begin
                if (out_fire) begin
                    if (rem_reg != '0) begin
                        ram_re         = 1'b1;
                        ram_raddr      = rd_idx_reg;
                        rd_idx_next    = wrap_add(rd_idx_reg, CNT_W'(1));
                        rem_next       = rem_reg - CNT_W'(1);
                        out_valid_next = 1'b0;
                        state_next     = ST_LOAD;
                    end else if (spill_pend_reg) begin
                        // The task that did not fit closes the spill run.
                        out_task_next   = hold_task_reg;
                        out_last_next   = 1'b1;
                        spill_pend_next = 1'b0;
                    end else begin
                        out_valid_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            next_task_reg  <= '0;
            next_valid_reg <= 1'b0;
            rem_reg        <= '0;
            spill_pend_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            next_task_reg  <= next_task_next;
            next_valid_reg <= next_valid_next;
            rem_reg        <= rem_next;
            spill_pend_reg <= spill_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg      <= rd_idx_next;
        hold_task_reg   <= hold_task_next;
        run_kind_reg    <= run_kind_next;
        empty_reg       <= empty_next;
        out_task_reg    <= out_task_next;
        out_kind_reg    <= out_kind_next;
        out_inherit_reg <= out_inherit_next;
        out_last_reg    <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {(M_TDATA_W - ID_W - 2)'(0), empty_reg, out_inherit_reg,
                            ID_W'(out_task_reg)};

    `WSRQ_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(RING_DEPTH),
        "ring entry count exceeds the ring depth")
    `WSRQ_ASSERT_ALWAYS(a_head_bound, head_reg < IDX_W'(RING_DEPTH - 1) ||
        head_reg == IDX_W'(RING_DEPTH - 1), "head index outside the ring")
    `WSRQ_ASSERT_SAME(a_no_overlap, s_axis_tready, !m_axis_tvalid,
        "command accepted while a result is still pending")
    `WSRQ_ASSERT_NEXT(a_last_ends_run, out_fire && out_last_reg, s_axis_tready,
        "sequencer did not return to idle after the final result")
    `WSRQ_ASSERT_SAME(a_spill_kind, spill_pend_reg, run_kind_reg == KIND_SPILL,
        "pending spill task in a run that is not a spill")

endmodule

@@ sim/work_stealing_run_queue_top_tb.sv @@
module work_stealing_run_queue_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wsrq_pkg::*;

    // The fourth action code has no name in the package; the block ignores it.
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 185;
    localparam int DRAIN_CYCLES = 200;
    // The slowest correct run is far below this, even with every command spilling
    // 33 results and each result behind the longest receiver stall.
    localparam int CYCLE_LIMIT  = 3_000_000;

    // One command on the slave channel. Directed rows may carry the single
    // result that they must produce; all other rows are checked against the
    // run-queue model below.
    typedef struct {
        logic [ACT_W-1:0]  action;
        logic [ID_W-1:0]   tid;
        logic              as_next;
        logic              steal;
        int                reps;
        bit                typed;
        logic [KIND_W-1:0] x_kind;
        logic [ID_W-1:0]   x_tid;
        logic              x_inherit;
        logic              x_empty;
    } cmd_t;

    // One result transaction as the master channel should present it.
    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   tid;
        logic              inherit;
        logic              last;
        logic              is_empty;
    } result_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [ACT_W-1:0]     s_axis_tuser  = ACT_PUT;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]    m_axis_tuser;
    logic                 m_axis_tlast;

    // The command currently offered on the slave channel, updated together
    // with tvalid and tdata so that the watcher sees the matching one.
    cmd_t    offered_cmd;
    result_t queued_results[$];
    cmd_t    dir_table[$];

    // Model state of the run queue.
    logic [TASK_BITS-1:0] model_ring [RING_DEPTH];
    int                   model_head  = 0;
    int                   model_count = 0;
    logic [TASK_BITS-1:0] model_next  = '0;
    bit                   model_next_valid = 1'b0;

    int mismatches  = 0;
    int cycle_count = 0;
    int rx_hold     = 0;
    bit rx_quiet    = 1'b0;
    bit tx_quiet    = 1'b0;

    work_stealing_run_queue_top u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 aclk = ~aclk;

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap(input bit quiet);
        int unsigned p;
        if (quiet) begin
            return 0;
        end
        p = $urandom_range(0, 99);
        if (p < 55) begin
            return 0;
        end else if (p < 85) begin
            return $urandom_range(1, 3);
        end else if (p < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(11, 40);
    endfunction

    function automatic cmd_t plain_row(input logic [ACT_W-1:0] action,
                                       input logic [ID_W-1:0] tid,
                                       input logic as_next, input logic steal,
                                       input int reps);
        cmd_t c;
        c = '{action: action, tid: tid, as_next: as_next, steal: steal,
              reps: reps, typed: 1'b0, x_kind: KIND_NONE, x_tid: '0,
              x_inherit: 1'b0, x_empty: 1'b0};
        return c;
    endfunction

    // A get or grab whose single result is written out in the table.
    function automatic cmd_t typed_row(input logic [ACT_W-1:0] action,
                                       input logic steal,
                                       input logic [KIND_W-1:0] kind,
                                       input logic [ID_W-1:0] tid,
                                       input logic inherit, input logic is_empty);
        cmd_t c;
        c = plain_row(action, 16'h0000, 1'b0, steal, 1);
        c.typed     = 1'b1;
        c.x_kind    = kind;
        c.x_tid     = tid;
        c.x_inherit = inherit;
        c.x_empty   = is_empty;
        return c;
    endfunction

    // Random command. The bias selects filling, mixed or draining traffic so
    // that the ring regularly reaches full and regularly empties again.
    function automatic cmd_t random_cmd(input int bias);
        cmd_t        c;
        int unsigned p;
        int          put_pct;
        int          get_pct;
        put_pct = (bias == 0) ? 90 : (bias == 1) ? 50 : 20;
        get_pct = (bias == 0) ? 5 : (bias == 1) ? 28 : 44;
        p = $urandom_range(0, 99);
        c = plain_row(ACT_PUT, 16'($urandom), 1'b0, 1'($urandom), 1);
        if (p < put_pct) begin
            c.action = ACT_PUT;
        end else if (p < put_pct + get_pct) begin
            c.action = ACT_GET;
        end else if (p < 97) begin
            c.action = ACT_GRAB;
        end else begin
            c.action = ACT_UNUSED;
        end
        c.as_next = ($urandom_range(0, 3) == 0);
        p = $urandom_range(0, 9);
        if (p == 0) begin
            c.tid = '0;
        end else if (p == 1) begin
            c.tid = '1;
        end
        return c;
    endfunction

    // Run-queue model: applies one accepted command and queues the result
    // transactions that it must cause.
    task automatic queue_step(input cmd_t c);
        result_t produced[$];
        result_t r;
        logic [TASK_BITS-1:0] carried;
        logic [TASK_BITS-1:0] displaced;
        bit had_next;
        int take;
        carried = c.tid;
        r = '{kind: KIND_NONE, tid: '0, inherit: 1'b0, last: 1'b1, is_empty: 1'b0};
        case (c.action)
            ACT_PUT: begin
                if (c.as_next) begin
                    had_next  = model_next_valid;
                    displaced = model_next;
                    model_next       = c.tid;
                    model_next_valid = 1'b1;
                    if (!had_next) begin
                        return;
                    end
                    // The task pushed out of the next slot joins the ring.
                    carried = displaced;
                end
                if (model_count < RING_DEPTH) begin
                    model_ring[(model_head + model_count) % RING_DEPTH] = carried;
                    model_count++;
                    return;
                end
                // Full ring: the older half goes out, then the incoming task.
                take = model_count / 2;
                for (int i = 0; i < take; i++) begin
                    produced.push_back('{KIND_SPILL,
                        model_ring[(model_head + i) % RING_DEPTH], 1'b0, 1'b0, 1'b0});
                end
                produced.push_back('{KIND_SPILL, carried, 1'b0, 1'b1, 1'b0});
                model_head  = (model_head + take) % RING_DEPTH;
                model_count = model_count - take;
            end
            ACT_GET: begin
                if (model_next_valid) begin
                    r.kind = KIND_RUN;
                    r.tid = model_next;
                    r.inherit = 1'b1;
                    model_next_valid = 1'b0;
                    model_next = '0;
                end else if (model_count != 0) begin
                    r.kind = KIND_RUN;
                    r.tid = model_ring[model_head];
                    model_head  = (model_head + 1) % RING_DEPTH;
                    model_count--;
                end
                produced.push_back(r);
            end
            ACT_GRAB: begin
                take = model_count - model_count / 2;
                if (take == 0) begin
                    // An empty ring only gives up the next slot when allowed.
                    if (c.steal && model_next_valid) begin
                        r.kind = KIND_THIEF;
                        r.tid = model_next;
                        model_next_valid = 1'b0;
                        model_next = '0;
                    end
                    produced.push_back(r);
                end else begin
                    for (int i = 0; i < take; i++) begin
                        produced.push_back('{KIND_THIEF,
                            model_ring[(model_head + i) % RING_DEPTH], 1'b0,
                            (i + 1 == take), 1'b0});
                    end
                    model_head  = (model_head + take) % RING_DEPTH;
                    model_count = model_count - take;
                end
            end
            default: begin
                return;
            end
        endcase
        if (c.typed) begin
            produced = '{'{c.x_kind, c.x_tid, c.x_inherit, 1'b1, c.x_empty}};
        end
        foreach (produced[i]) begin
            produced[i].is_empty = (model_count == 0) && !model_next_valid;
            if (c.typed) begin
                produced[i].is_empty = c.x_empty;
            end
            queued_results.push_back(produced[i]);
        end
    endtask

    // Offers one command after a random idle gap and waits for its handshake.
    task automatic send_cmd(input cmd_t c);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.action;
        s_axis_tdata  <= S_TDATA_W'({c.steal, c.as_next, c.tid});
        offered_cmd   <= c;
        do begin
            @(posedge aclk);
        end while (!s_axis_tready);
    endtask

    // Receiver: tready drops for random stretches, except in quiet phases.
    always @(posedge aclk) begin : rx_stall
        int g;
        if (rx_hold != 0) begin
            rx_hold       <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            g = ($urandom_range(0, 4) == 0) ? pick_gap(rx_quiet) : 0;
            if (g != 0) begin
                rx_hold       <= g - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watches both channels at each rising edge. Everything the testbench
    // drives changes by nonblocking assignment, so the values read here are
    // the ones the block itself sampled at this edge.
    always @(posedge aclk) begin : watch
        result_t              want;
        logic [M_TDATA_W-1:0] want_data;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                queue_step(offered_cmd);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (queued_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected result transaction: kind %0d tdata %h last %b",
                                 $realtime, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    end
                end else begin
                    want      = queued_results.pop_front();
                    want_data = M_TDATA_W'({want.is_empty, want.inherit, want.tid});
                    if (m_axis_tuser !== want.kind || m_axis_tdata !== want_data ||
                        m_axis_tlast !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: result mismatch: kind %0d/%0d tdata %h/%h last %b/%b",
                                     $realtime, m_axis_tuser, want.kind, m_axis_tdata,
                                     want_data, m_axis_tlast, want.last);
                        end
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        cmd_t c;
        int   n_random;
        int   bias;
        int   burst;

        // Directed part. After reset both sides are empty; the next slot is
        // then exercised, the ring is filled to the point of spilling (once by
        // a plain put, once by a next-slot put that displaces a task), and
        // grabs then halve the ring until nothing is left.
        dir_table.push_back(typed_row(ACT_GET, 1'b0, KIND_NONE, 16'h0000, 1'b0, 1'b1));
        dir_table.push_back(typed_row(ACT_GRAB, 1'b1, KIND_NONE, 16'h0000, 1'b0, 1'b1));
        dir_table.push_back(plain_row(ACT_UNUSED, 16'hFFFF, 1'b1, 1'b1, 1));
        dir_table.push_back(plain_row(ACT_PUT, 16'hFFFF, 1'b0, 1'b1, 1));
        dir_table.push_back(plain_row(ACT_PUT, 16'h0000, 1'b1, 1'b0, 1));
        dir_table.push_back(plain_row(ACT_PUT, 16'h1234, 1'b1, 1'b0, 1));
        dir_table.push_back(typed_row(ACT_GET, 1'b0, KIND_RUN, 16'h1234, 1'b1, 1'b0));
        dir_table.push_back(typed_row(ACT_GET, 1'b1, KIND_RUN, 16'hFFFF, 1'b0, 1'b0));
        dir_table.push_back(typed_row(ACT_GET, 1'b0, KIND_RUN, 16'h0000, 1'b0, 1'b1));
        dir_table.push_back(plain_row(ACT_PUT, 16'hABCD, 1'b1, 1'b0, 1));
        dir_table.push_back(typed_row(ACT_GRAB, 1'b0, KIND_NONE, 16'h0000, 1'b0, 1'b0));
        dir_table.push_back(typed_row(ACT_GRAB, 1'b1, KIND_THIEF, 16'hABCD, 1'b0, 1'b1));
        dir_table.push_back(plain_row(ACT_PUT, 16'h0100, 1'b0, 1'b0, RING_DEPTH));
        dir_table.push_back(plain_row(ACT_PUT, 16'h8000, 1'b0, 1'b1, 1));
        dir_table.push_back(plain_row(ACT_PUT, 16'h7777, 1'b1, 1'b0, 1));
        dir_table.push_back(plain_row(ACT_PUT, 16'h0200, 1'b0, 1'b0, RING_DEPTH / 2));
        dir_table.push_back(plain_row(ACT_PUT, 16'h5555, 1'b1, 1'b0, 1));
        dir_table.push_back(plain_row(ACT_UNUSED, 16'h0000, 1'b0, 1'b0, 1));
        dir_table.push_back(plain_row(ACT_GRAB, 16'h0000, 1'b0, 1'b1, 1));
        dir_table.push_back(typed_row(ACT_GET, 1'b0, KIND_RUN, 16'h5555, 1'b1, 1'b0));
        dir_table.push_back(plain_row(ACT_GRAB, 16'h0000, 1'b0, 1'b1, 5));
        dir_table.push_back(typed_row(ACT_GRAB, 1'b1, KIND_NONE, 16'h0000, 1'b0, 1'b1));
        dir_table.push_back(typed_row(ACT_GET, 1'b1, KIND_NONE, 16'h0000, 1'b0, 1'b1));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_table[i]) begin
            for (int r = 0; r < dir_table[i].reps; r++) begin
                c = dir_table[i];
                c.tid = c.tid + ID_W'(r);
                send_cmd(c);
            end
        end

        // Random part in bursts of filling, mixed or draining traffic; some
        // bursts run with either side never idling.
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            bias  = $urandom_range(0, 9);
            bias  = (bias < 4) ? 0 : (bias < 7) ? 1 : 2;
            burst = (bias == 0) ? $urandom_range(20, 80) : $urandom_range(8, 40);
            tx_quiet = ($urandom_range(0, 4) == 0);
            rx_quiet <= ($urandom_range(0, 4) == 0);
            for (int k = 0; k < burst && n_random < RANDOM_ITEMS; k++) begin
                c = random_cmd(bias);
                send_cmd(c);
                if (c.action != ACT_UNUSED) begin
                    n_random++;
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        while (queued_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
